>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("priority ready queue check failed");

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("priority ready queue forbidden condition seen");

`endif

>>> hw/rtl/prq_pkg.sv
// types and codes of the priority ready queue
// no dependencies
package prq_pkg;

  // action codes
  localparam logic [2:0] ACT_REGISTER = 3'd0;
  localparam logic [2:0] ACT_INSERT   = 3'd1;
  localparam logic [2:0] ACT_EXTRACT  = 3'd2;
  localparam logic [2:0] ACT_READ     = 3'd3;
  localparam logic [2:0] ACT_NEW_RUN  = 3'd4;
  localparam logic [2:0] ACT_DISCARD  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_REG     = 2'd1;
  localparam logic [1:0] ST_ALREADY_REG = 2'd2;
  localparam logic [1:0] ST_ALREADY_Q   = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic [4:0]         task_id;
    logic signed [31:0] priority_req;
    logic [31:0]        now;
    logic [4:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] result_task;
    logic       result_valid;
    logic [5:0] queue_count;
  } out_item_t;

  // comparator result
  typedef struct packed {
    logic gt;       // new tuple strictly above stored tuple
    logic task_eq;  // stored task id equals new task id
  } cmp_res_t;

endpackage

>>> hw/rtl/prq_if.sv
// valid/ready channels of the priority ready queue
// depends on prq_pkg
interface prq_in_if;
  import prq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prq_out_if;
  import prq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/priority_ready_queue.sv
// priority ready queue top level: sequencer, masks and output register
// depends on prq_pkg, prq_if, prq_cmp, prq_store

// Ready queue of task ids kept in descending (priority, insert time, task id)
// order in an entry memory with one write and one read port. Every item yields
// exactly one result. Register, new run, discard, unused actions, a read past
// the end and any request that leaves the queue as it is go from accept
// straight to S_DONE; a read inside the queue passes S_RD first. Insert walks
// the queue from its tail, one entry a cycle through the shared comparator,
// moving each smaller entry down one place. Extract of a queued task walks
// from the head, finds the task and moves each later entry up one place.
// Each walk step uses the one read and one write port of the entry memory.
// The input side takes no item while a walk is under way; a finished result
// sits in an output register, so the next item can be taken while that
// result waits.
module priority_ready_queue #(
  parameter int TASK_SLOTS = 32,
  parameter int TIME_BITS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  prq_in_if.sink           in_i,
  prq_out_if.source        out_o
);
  import prq_pkg::*;

  localparam int AW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int DW = 5 + 32 + TIME_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;  // walk from tail, shift down
  localparam logic [2:0] S_PUT  = 3'd2;  // write new entry at j
  localparam logic [2:0] S_EXT  = 3'd3;  // walk from head, shift up
  localparam logic [2:0] S_RD   = 3'd4;  // read data arrives
  localparam logic [2:0] S_DONE = 3'd5;  // hand result to output register

  // control state
  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         j_q, j_d;
  logic                  found_q, found_d;
  logic [TASK_SLOTS-1:0] regm_q, regm_d;
  logic [TASK_SLOTS-1:0] qm_q, qm_d;
  logic                  out_valid_q, out_valid_d;

  // item and result payload
  logic [4:0]            id_q, id_d;
  logic signed [31:0]    prio_q, prio_d;
  logic [TIME_BITS-1:0]  time_q, time_d;
  logic [1:0]            status_q, status_d;
  logic [4:0]            rtask_q, rtask_d;
  logic                  rvalid_q, rvalid_d;
  out_item_t             out_data_q, out_data_d;

  // memory port
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DW-1:0]         wdata, rdata, new_entry;
  logic [4:0]            rd_task;
  logic signed [31:0]    rd_prio;
  logic [TIME_BITS-1:0]  rd_time;
  cmp_res_t              cmp;

  // decode of the incoming item
  logic                  in_acc, in_range, in_reg, in_qd;
  logic [AW-1:0]         in_idx, id_idx;

  assign new_entry = {id_q, prio_q, time_q};
  assign rd_task   = rdata[DW-1 -: 5];
  assign rd_prio   = $signed(rdata[TIME_BITS+31 -: 32]);
  assign rd_time   = rdata[TIME_BITS-1:0];

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_idx   = AW'(in_i.data.task_id);
  assign id_idx   = AW'(id_q);
  assign in_range = 9'(in_i.data.task_id) < 9'(TASK_SLOTS);
  assign in_reg   = in_range && regm_q[in_idx];
  assign in_qd    = in_range && qm_q[in_idx];

  assign in_i.ready = state_q == S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  prq_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .a_prio_i (prio_q),
    .a_time_i (time_q),
    .a_task_i (id_q),
    .b_prio_i (rd_prio),
    .b_time_i (rd_time),
    .b_task_i (rd_task),
    .res_o    (cmp)
  );

  prq_store #(
    .DEPTH (TASK_SLOTS),
    .DW    (DW),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    found_d     = found_q;
    regm_d      = regm_q;
    qm_d        = qm_q;
    out_valid_d = out_valid_q;
    id_d        = id_q;
    prio_d      = prio_q;
    time_d      = time_q;
    status_d    = status_q;
    rtask_d     = rtask_q;
    rvalid_d    = rvalid_q;
    out_data_d  = out_data_q;
    we          = 1'b0;
    waddr       = j_q + AW'(1);
    wdata       = new_entry;
    raddr       = j_q;

    // result taken downstream
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          id_d     = in_i.data.task_id;
          prio_d   = in_i.data.priority_req;
          time_d   = TIME_BITS'(in_i.data.now);
          status_d = ST_OK;
          rtask_d  = 5'd0;
          rvalid_d = 1'b0;
          state_d  = S_DONE;
          case (in_i.data.action)
            ACT_REGISTER: begin
              if (!in_range) begin
                status_d = ST_NOT_REG;
              end else if (regm_q[in_idx]) begin
                status_d = ST_ALREADY_REG;
              end else begin
                regm_d[in_idx] = 1'b1;
              end
            end
            ACT_INSERT: begin
              if (!in_reg) begin
                status_d = ST_NOT_REG;
              end else if (in_qd) begin
                status_d = ST_ALREADY_Q;
              end else if (9'(cnt_q) < 9'(TASK_SLOTS)) begin
                if (cnt_q == '0) begin
                  // empty queue: new entry goes straight to the head
                  j_d     = '0;
                  state_d = S_PUT;
                end else begin
                  raddr   = AW'(cnt_q - CW'(1));
                  j_d     = AW'(cnt_q - CW'(1));
                  state_d = S_INS;
                end
              end
            end
            ACT_EXTRACT: begin
              if (!in_reg) begin
                status_d = ST_NOT_REG;
              end else if (in_qd) begin
                raddr   = '0;
                j_d     = '0;
                found_d = 1'b0;
                state_d = S_EXT;
              end
            end
            ACT_READ: begin
              if (9'(in_i.data.position) < 9'(cnt_q)) begin
                raddr   = AW'(in_i.data.position);
                state_d = S_RD;
              end
            end
            ACT_NEW_RUN: begin
              qm_d  = '0;
              cnt_d = '0;
            end
            ACT_DISCARD: begin
              qm_d   = '0;
              regm_d = '0;
              cnt_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        // entry j sits in rdata; move it down while the new tuple is larger
        we = 1'b1;
        if (cmp.gt) begin
          wdata = rdata;
          if (j_q == '0) begin
            state_d = S_PUT;
          end else begin
            raddr = j_q - AW'(1);
            j_d   = j_q - AW'(1);
          end
        end else begin
          cnt_d        = cnt_q + CW'(1);
          qm_d[id_idx] = 1'b1;
          state_d      = S_DONE;
        end
      end

      S_PUT: begin
        we           = 1'b1;
        waddr        = j_q;
        cnt_d        = cnt_q + CW'(1);
        qm_d[id_idx] = 1'b1;
        state_d      = S_DONE;
      end

      S_EXT: begin
        // past the match every entry moves up one place
        if (found_q) begin
          we    = 1'b1;
          waddr = j_q - AW'(1);
          wdata = rdata;
        end else if (cmp.task_eq) begin
          found_d = 1'b1;
        end
        if (CW'(j_q) + CW'(1) == cnt_q) begin
          cnt_d        = cnt_q - CW'(1);
          qm_d[id_idx] = 1'b0;
          state_d      = S_DONE;
        end else begin
          raddr = j_q + AW'(1);
          j_d   = j_q + AW'(1);
        end
      end

      S_RD: begin
        rtask_d  = rd_task;
        rvalid_d = 1'b1;
        state_d  = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_data_d.status       = status_q;
          out_data_d.result_task  = rtask_q;
          out_data_d.result_valid = rvalid_q;
          out_data_d.queue_count  = 6'(cnt_q);
          out_valid_d             = 1'b1;
          state_d                 = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      j_q         <= '0;
      found_q     <= 1'b0;
      regm_q      <= '0;
      qm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      found_q     <= found_d;
      regm_q      <= regm_d;
      qm_q        <= qm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    prio_q     <= prio_d;
    time_q     <= time_d;
    status_q   <= status_d;
    rtask_q    <= rtask_d;
    rvalid_q   <= rvalid_d;
    out_data_q <= out_data_d;
  end

endmodule

>>> hw/rtl/prq_cmp.sv
// shared tuple comparator: (priority, time, task id) order and id match
// depends on prq_pkg
module prq_cmp #(
  parameter int TIME_BITS = 32
) (
  input  logic signed [31:0]    a_prio_i,
  input  logic [TIME_BITS-1:0]  a_time_i,
  input  logic [4:0]            a_task_i,
  input  logic signed [31:0]    b_prio_i,
  input  logic [TIME_BITS-1:0]  b_time_i,
  input  logic [4:0]            b_task_i,
  output prq_pkg::cmp_res_t     res_o
);
  import prq_pkg::*;

  always_comb begin
    if (a_prio_i != b_prio_i) begin
      res_o.gt = a_prio_i > b_prio_i;
    end else if (a_time_i != b_time_i) begin
      res_o.gt = a_time_i > b_time_i;
    end else begin
      res_o.gt = a_task_i > b_task_i;
    end
    res_o.task_eq = a_task_i == b_task_i;
  end

endmodule

>>> hw/rtl/prq_store.sv
// queue entry memory: one write port, one registered read port
// no dependencies
module prq_store #(
  parameter int DEPTH = 32,
  parameter int DW    = 69,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/prq_check.sv
// port-level checks of the priority ready queue, bound to the top level
// depends on prq_pkg, assert_macros.svh, priority_ready_queue
`include "assert_macros.svh"

module prq_check (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input prq_pkg::out_item_t  out_data_i
);
  import prq_pkg::*;

  // a waiting result holds until taken
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))

  // the input side is not ready in the cycle after an item is taken
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)

  // a miss or a non-read reports task zero
  `ASSERT_CLK(a_task_zero_on_miss, clk_i, rst_ni, out_valid_i && !out_data_i.result_valid |-> out_data_i.result_task == 5'd0)

  // a successful read never carries an error
  `ASSERT_NEVER(a_read_no_error, clk_i, rst_ni, out_valid_i && out_data_i.result_valid && out_data_i.status != ST_OK)

endmodule

bind priority_ready_queue prq_check u_prq_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

>>> test/prq_queue_checker.sv
// result checker of the priority ready queue: keeps its own copy of the
// registry and the ordered queue, predicts each result and compares it
// depends on prq_pkg
module prq_queue_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_ready_i,
  input  prq_pkg::in_item_t  req_item_i,
  input  logic               rsp_valid_i,
  input  logic               rsp_ready_i,
  input  prq_pkg::out_item_t rsp_item_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 read_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import prq_pkg::*;

  localparam int SLOTS = 32;

  logic               is_registered [SLOTS];
  logic               is_queued     [SLOTS];
  logic [4:0]         slot_task     [SLOTS];
  logic signed [31:0] slot_prio     [SLOTS];
  logic [31:0]        slot_stamp    [SLOTS];
  int                 queue_len;
  out_item_t          expected_replies [$];
  int                 mismatches;
  int                 checked;
  int                 read_hits;

  // true if the new tuple orders strictly ahead of the entry at slot
  function automatic bit ranks_above(input logic signed [31:0] prio,
                                     input logic [31:0] stamp,
                                     input logic [4:0] id,
                                     input logic [4:0] slot);
    if (prio != slot_prio[slot]) return prio > slot_prio[slot];
    if (stamp != slot_stamp[slot]) return stamp > slot_stamp[slot];
    return id > slot_task[slot];
  endfunction

  // updates the mirrored queue and returns the result it should give
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t rsp;
    int        at;
    rsp = '0;
    rsp.status = ST_OK;
    case (req.action)
      ACT_REGISTER: begin
        if (is_registered[req.task_id]) rsp.status = ST_ALREADY_REG;
        else is_registered[req.task_id] = 1'b1;
      end
      ACT_INSERT: begin
        if (!is_registered[req.task_id]) begin
          rsp.status = ST_NOT_REG;
        end else if (is_queued[req.task_id]) begin
          rsp.status = ST_ALREADY_Q;
        end else if (queue_len < SLOTS) begin
          at = 0;
          while (at < queue_len &&
                 !ranks_above(req.priority_req, req.now, req.task_id, 5'(at))) at++;
          for (int j = queue_len; j > at; j--) begin
            slot_task[5'(j)]  = slot_task[5'(j-1)];
            slot_prio[5'(j)]  = slot_prio[5'(j-1)];
            slot_stamp[5'(j)] = slot_stamp[5'(j-1)];
          end
          slot_task[5'(at)]  = req.task_id;
          slot_prio[5'(at)]  = req.priority_req;
          slot_stamp[5'(at)] = req.now;
          queue_len++;
          is_queued[req.task_id] = 1'b1;
        end
      end
      ACT_EXTRACT: begin
        if (!is_registered[req.task_id]) begin
          rsp.status = ST_NOT_REG;
        end else if (is_queued[req.task_id]) begin
          at = 0;
          while (at < queue_len && slot_task[5'(at)] != req.task_id) at++;
          if (at < queue_len) begin
            for (int j = at; j + 1 < queue_len; j++) begin
              slot_task[5'(j)]  = slot_task[5'(j+1)];
              slot_prio[5'(j)]  = slot_prio[5'(j+1)];
              slot_stamp[5'(j)] = slot_stamp[5'(j+1)];
            end
            queue_len--;
          end
          is_queued[req.task_id] = 1'b0;
        end
      end
      ACT_READ: begin
        if (req.position < queue_len) begin
          rsp.result_task  = slot_task[req.position];
          rsp.result_valid = 1'b1;
          read_hits++;
        end
      end
      ACT_NEW_RUN: begin
        foreach (is_queued[i]) is_queued[i] = 1'b0;
        queue_len = 0;
      end
      ACT_DISCARD: begin
        foreach (is_queued[i]) is_queued[i] = 1'b0;
        foreach (is_registered[i]) is_registered[i] = 1'b0;
        queue_len = 0;
      end
      default: ;
    endcase
    rsp.queue_count = queue_len[5:0];
    return rsp;
  endfunction

  function automatic void check_field(input string field, input int want,
                                      input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (is_registered[i]) is_registered[i] = 1'b0;
      foreach (is_queued[i]) is_queued[i] = 1'b0;
      queue_len = 0;
      expected_replies.delete();
      mismatches = 0;
      checked = 0;
      read_hits = 0;
    end else begin
      if (req_valid_i && req_ready_i) expected_replies.push_back(apply_request(req_item_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_replies.size() == 0) begin
          $display("%0t ns: result with none expected, expected nothing, actual %p",
                   $time, rsp_item_i);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", int'(want.status), int'(rsp_item_i.status));
          check_field("result_task", int'(want.result_task),
                      int'(rsp_item_i.result_task));
          check_field("result_valid", int'(want.result_valid),
                      int'(rsp_item_i.result_valid));
          check_field("queue_count", int'(want.queue_count),
                      int'(rsp_item_i.queue_count));
          checked++;
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_replies.size();
    checked_o    <= checked;
    read_hits_o  <= read_hits;
  end

endmodule

>>> test/priority_ready_queue_tb.sv
// testbench top of the priority ready queue: clock, reset, stimulus and verdict
// depends on prq_pkg, prq_if, priority_ready_queue and prq_queue_checker
module priority_ready_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prq_pkg::*;

  localparam int         ITEM_COUNT  = 1150;
  localparam int         IDLE_PCT    = 37;
  localparam int         DRAIN_LIMIT = 5000;
  localparam int         TAIL_CYCLES = 40;  // longer than a full-queue walk
  // the two action codes the block leaves unused
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam logic signed [31:0] PRIO_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] PRIO_MIN = 32'sh80000000;
  localparam logic [31:0]        STAMP_MAX = 32'hffffffff;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm;  // when set neither side idles

  int fails, pending, checked, read_hits;
  int sent, inserts, extracts, reads, guard;

  prq_in_if  req_if ();
  prq_out_if rsp_if ();

  priority_ready_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  prq_queue_checker queue_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_item_i   (req_if.data),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_item_i   (rsp_if.data),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked),
    .read_hits_o  (read_hits)
  );

  always #6 clk_i = ~clk_i;

  // result side: back-pressure at random, none during the calm stretch
  always @(posedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // hands one item to the block and returns at the edge that takes it;
  // valid stays high so back-to-back items need no second assignment
  task automatic send(input in_item_t req);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
    case (req.action)
      ACT_INSERT:  inserts++;
      ACT_EXTRACT: extracts++;
      ACT_READ:    reads++;
      default: ;
    endcase
  endtask

  task automatic issue(input logic [2:0] act, input logic [4:0] id,
                       input logic signed [31:0] prio, input logic [31:0] stamp,
                       input logic [4:0] pos);
    in_item_t req;
    req.action       = act;
    req.task_id      = id;
    req.priority_req = prio;
    req.now          = stamp;
    req.position     = pos;
    send(req);
  endtask

  // holds the input side until every expected result has come back or the guard runs out
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // priorities and stamps come often from a few corner values so that
  // ties fall through to the insert time and then to the task id
  function automatic logic signed [31:0] pick_prio();
    if ($urandom_range(3) != 0) return $urandom;
    case ($urandom_range(4))
      0: return PRIO_MIN;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return PRIO_MAX;
    endcase
  endfunction

  function automatic logic [31:0] pick_stamp();
    if ($urandom_range(9) >= 3) return $urandom;
    case ($urandom_range(2))
      0: return 32'd0;
      1: return 32'd1;
      default: return STAMP_MAX;
    endcase
  endfunction

  // mostly queue traffic on random task ids, with rare clears and noise
  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    pick             = $urandom_range(99);
    req.task_id      = 5'($urandom_range(31));
    req.priority_req = pick_prio();
    req.now          = pick_stamp();
    // reads lean toward the front where the queue is usually filled
    req.position     = $urandom_range(1) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
    if (pick < 12) req.action = ACT_REGISTER;
    else if (pick < 45) req.action = ACT_INSERT;
    else if (pick < 66) req.action = ACT_EXTRACT;
    else if (pick < 94) req.action = ACT_READ;
    else if (pick < 96) req.action = ACT_NEW_RUN;
    else if (pick < 97) req.action = ACT_DISCARD;
    else if (pick < 99) req.action = ACT_SPARE_A;
    else req.action = ACT_SPARE_B;
    return req;
  endfunction

  // registers every task and queues all of them: full queue, longest walks
  task automatic fill_queue();
    for (int id = 0; id < 32; id++) begin
      issue(ACT_REGISTER, 5'(id), 0, 0, 0);
      issue(ACT_INSERT, 5'(id), pick_prio(), pick_stamp(), 5'($urandom_range(31)));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    calm         = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    sent = 0;
    inserts = 0;
    extracts = 0;
    reads = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queue, duplicates, rejects, tie-breaks and clears
    issue(ACT_READ, 0, 0, 0, 0);                       // read of empty queue
    issue(ACT_REGISTER, 31, 0, 0, 0);
    issue(ACT_REGISTER, 0, 0, 0, 0);
    issue(ACT_REGISTER, 31, 0, 0, 0);                  // registered twice
    issue(ACT_INSERT, 5, 0, 0, 0);                     // insert unregistered
    issue(ACT_EXTRACT, 5, 0, 0, 0);                    // extract unregistered
    issue(ACT_INSERT, 31, PRIO_MAX, STAMP_MAX, 0);
    issue(ACT_INSERT, 0, PRIO_MIN, 0, 0);
    issue(ACT_INSERT, 31, 0, 0, 0);                    // already queued
    issue(ACT_REGISTER, 7, 0, 0, 0);
    issue(ACT_EXTRACT, 7, 0, 0, 0);                    // registered, not queued
    issue(ACT_REGISTER, 3, 0, 0, 0);
    issue(ACT_INSERT, 3, PRIO_MAX, STAMP_MAX, 0);      // tie down to task id
    issue(ACT_REGISTER, 9, 0, 0, 0);
    issue(ACT_INSERT, 9, PRIO_MAX, STAMP_MAX - 1, 0);  // tie on priority only
    issue(ACT_READ, 0, 0, 0, 0);
    issue(ACT_READ, 0, 0, 0, 3);
    issue(ACT_READ, 0, 0, 0, 31);                      // past the end
    issue(ACT_EXTRACT, 31, 0, 0, 0);
    issue(ACT_READ, 0, 0, 0, 0);
    issue(ACT_SPARE_A, 31, PRIO_MAX, STAMP_MAX, 31);
    issue(ACT_SPARE_B, 0, 0, 0, 0);
    issue(ACT_NEW_RUN, 0, 0, 0, 0);
    issue(ACT_DISCARD, 0, 0, 0, 0);
    issue(ACT_INSERT, 0, 0, 0, 0);                     // registry was emptied

    // random part with full-queue bursts, a calm stretch and one drain
    for (int n = 0; n < ITEM_COUNT; n++) begin
      if (n == 300 || n == 800) fill_queue();
      if (n == 350) calm <= 1'b1;
      if (n == 550) calm <= 1'b0;
      if (n == 600) drain();
      send(random_request());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run covered %0d items: %0d inserts, %0d extracts, %0d reads",
             sent, inserts, extracts, reads);
    $display("%0d results compared, %0d reads landed inside the queue",
             checked, read_hits);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
